[rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Assert a property on the rising clock edge, also checked during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

[rtl/ffha_pkg.sv]
// Constants and types of the first-fit heap allocator
`default_nettype none
package ffha_pkg;
   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 24;
   localparam int HDR_SPAN     = ((HEADER_BYTES + 7) / 8) * 8;
   localparam int GRANULES     = (HEAP_BYTES + 7) / 8;
   localparam int GRAN_W       = $clog2(GRANULES);
   localparam int OFF_W        = 18;
   localparam int SIZE_W       = 17;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NULL = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              free;
   } hdr_type;
endpackage
`default_nettype wire

[rtl/first_fit_heap_allocator_unit.sv]
// Top level: first-fit heap allocator with split and coalesce over a header memory
//
//  channel | dir | ports          | contents
//  req     | in  | req_t*         | tuser: kind; tdata: req_size, addr
//  rsp     | out | rsp_t*         | tdata: status, result_addr, granted_size
//
// A request makes one memory read per header walked, and a free that finds its
// block then visits the blocks again in a coalesce pass.
// Reset empties the arena at once; the header memory needs no clearing pass.
// A request is taken only in idle; a result waiting on rsp_tready holds the
// next result, not the next request.
`default_nettype none
module first_fit_heap_allocator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // req_size[16:0], addr[32:17], zeros
   input  wire logic [0:0]  req_tuser,   // kind[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // status[1:0], result_addr[17:2],
                                         // granted_size[34:18], zeros
);
   import ffha_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WALK  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_SPLIT = 4'd3;
   localparam logic [3:0] S_MRDC  = 4'd4;
   localparam logic [3:0] S_MGETC = 4'd5;
   localparam logic [3:0] S_MNXT  = 4'd6;
   localparam logic [3:0] S_MGETN = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   hdr_type hdr_mem [GRANULES];
   hdr_type rdata_ff;

   logic [3:0]        state_ff, state_in;
   logic [SIZE_W-1:0] brk_ff, brk_in;
   logic [OFF_W-1:0]  cur_ff, cur_in, nxt_ff, nxt_in, s_ff, s_in;
   logic              kind_ff, kind_in;
   logic [15:0]       addr_ff, addr_in;
   hdr_type           hc_ff, hc_in;
   logic [1:0]        pst_ff, pst_in;
   logic [15:0]       paddr_ff, paddr_in;
   logic [SIZE_W-1:0] psize_ff, psize_in;
   logic              rv_ff, rv_in;
   logic [1:0]        rst_ff, rst_in;
   logic [15:0]       raddr_ff, raddr_in;
   logic [SIZE_W-1:0] rsize_ff, rsize_in;

   logic              mem_we, mem_re;
   logic [GRAN_W-1:0] mem_waddr, mem_raddr;
   hdr_type           mem_wdata;

   logic [SIZE_W-1:0] req_size;
   logic [15:0]       req_addr;
   logic [OFF_W:0]    end_sum, split_lim, nxt_calc;
   logic [OFF_W-1:0]  hsize;

   function automatic logic [GRAN_W-1:0] nxt_calc_split(input logic [OFF_W-1:0] c,
                                                        input logic [OFF_W-1:0] s);
      logic [OFF_W-1:0] o;
      o = c + OFF_W'(HDR_SPAN) + s;
      return o[GRAN_W+2:3];
   endfunction

   assign req_size  = req_tdata[16:0];
   assign req_addr  = req_tdata[32:17];
   assign hsize     = {1'b0, rdata_ff.size};
   assign end_sum   = {2'b0, brk_ff} + (OFF_W+1)'(HDR_SPAN) + {1'b0, s_ff};
   assign split_lim = {1'b0, s_ff} + (OFF_W+1)'(HDR_SPAN + 8);
   assign nxt_calc  = {1'b0, cur_ff} + (OFF_W+1)'(HDR_SPAN) + {2'b0, hc_ff.size};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {5'b0, rsize_ff, raddr_ff, rst_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hdr_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= hdr_mem[mem_raddr];
      end
   end

   always_comb begin
      state_in  = state_ff;
      brk_in    = brk_ff;
      cur_in    = cur_ff;
      nxt_in    = nxt_ff;
      s_in      = s_ff;
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      hc_in     = hc_ff;
      pst_in    = pst_ff;
      paddr_in  = paddr_ff;
      psize_in  = psize_ff;
      rv_in     = rv_ff && !rsp_tready;
      rst_in    = rst_ff;
      raddr_in  = raddr_ff;
      rsize_in  = rsize_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = cur_ff[GRAN_W+2:3];
      mem_raddr = cur_ff[GRAN_W+2:3];
      mem_wdata = rdata_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser[0];
               addr_in  = req_addr;
               s_in     = ({1'b0, req_size} + OFF_W'(7)) & ~OFF_W'(7);
               cur_in   = '0;
               pst_in   = ST_NULL;
               paddr_in = '0;
               psize_in = '0;
               if (req_tuser[0] == KIND_ALLOC) begin
                  state_in = (req_size == '0) ? S_OUT : S_WALK;
               end else begin
                  state_in = (req_addr == '0) ? S_OUT : S_WALK;
               end
            end
         end
         S_WALK: begin
            if (cur_ff >= {1'b0, brk_ff}) begin
               state_in = S_OUT;
               if (kind_ff == KIND_ALLOC) begin
                  if (end_sum > (OFF_W+1)'(HEAP_BYTES)) begin
                     pst_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = brk_ff[GRAN_W+2:3];
                     mem_wdata = '{size: s_ff[SIZE_W-1:0], free: 1'b0};
                     brk_in    = end_sum[SIZE_W-1:0];
                     pst_in    = ST_OK;
                     paddr_in  = 16'(brk_ff + SIZE_W'(HDR_SPAN));
                     psize_in  = s_ff[SIZE_W-1:0];
                  end
               end
            end else begin
               mem_re   = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            hc_in  = rdata_ff;
            cur_in = cur_ff + OFF_W'(HDR_SPAN) + hsize;
            state_in = S_WALK;
            if (kind_ff == KIND_ALLOC) begin
               if (rdata_ff.free && hsize >= s_ff) begin
                  cur_in   = cur_ff;
                  pst_in   = ST_OK;
                  paddr_in = 16'(cur_ff + OFF_W'(HDR_SPAN));
                  if ({1'b0, hsize} >= split_lim) begin
                     mem_we    = 1'b1;
                     mem_waddr = nxt_calc_split(cur_ff, s_ff);
                     mem_wdata = '{size: SIZE_W'(hsize - s_ff - OFF_W'(HDR_SPAN)),
                                   free: 1'b1};
                     psize_in  = s_ff[SIZE_W-1:0];
                     state_in  = S_SPLIT;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = '{size: rdata_ff.size, free: 1'b0};
                     psize_in  = rdata_ff.size;
                     state_in  = S_OUT;
                  end
               end
            end else if (cur_ff + OFF_W'(HDR_SPAN) == {2'b0, addr_ff}) begin
               mem_we    = 1'b1;
               mem_wdata = '{size: rdata_ff.size, free: 1'b1};
               cur_in    = '0;
               pst_in    = ST_OK;
               state_in  = S_MRDC;
            end
         end
         S_SPLIT: begin
            mem_we    = 1'b1;
            mem_wdata = '{size: s_ff[SIZE_W-1:0], free: 1'b0};
            state_in  = S_OUT;
         end
         S_MRDC: begin
            if (cur_ff >= {1'b0, brk_ff}) begin
               state_in = S_OUT;
            end else begin
               mem_re   = 1'b1;
               state_in = S_MGETC;
            end
         end
         S_MGETC: begin
            hc_in    = rdata_ff;
            state_in = S_MNXT;
         end
         S_MNXT: begin
            nxt_in = nxt_calc[OFF_W-1:0];
            if (nxt_calc >= {2'b0, brk_ff}) begin
               state_in = S_OUT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = nxt_calc[GRAN_W+2:3];
               state_in  = S_MGETN;
            end
         end
         S_MGETN: begin
            state_in = S_MNXT;
            if (hc_ff.free && rdata_ff.free) begin
               hc_in.size = hc_ff.size + SIZE_W'(HDR_SPAN) + rdata_ff.size;
               mem_we     = 1'b1;
               mem_wdata  = '{size: hc_in.size, free: 1'b1};
            end else begin
               cur_in = nxt_ff;
               hc_in  = rdata_ff;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               rst_in   = pst_ff;
               raddr_in = paddr_ff;
               rsize_in = psize_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         brk_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         brk_ff   <= brk_in;
         rv_ff    <= rv_in;
      end
      cur_ff   <= cur_in;
      nxt_ff   <= nxt_in;
      s_ff     <= s_in;
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      hc_ff    <= hc_in;
      pst_ff   <= pst_in;
      paddr_ff <= paddr_in;
      psize_ff <= psize_in;
      rst_ff   <= rst_in;
      raddr_ff <= raddr_in;
      rsize_ff <= rsize_in;
   end
endmodule
`default_nettype wire

[rtl/ffha_checker.sv]
// Port-level checker for the allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ffha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   import ffha_pkg::*;

   logic [1:0]  rsp_status;
   logic [15:0] rsp_addr;
   logic [16:0] rsp_size;

   assign rsp_status = rsp_tdata[1:0];
   assign rsp_addr   = rsp_tdata[17:2];
   assign rsp_size   = rsp_tdata[34:18];

   `CHK_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid)
   `CHK_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `CHK_ASSERT(a_fail_zero, clock, reset, rsp_tvalid && rsp_status != ST_OK |-> rsp_tdata[34:2] == '0)
   `CHK_ASSERT(a_grant_ok, clock, reset, rsp_tvalid && rsp_addr != '0 |-> rsp_status == ST_OK)
   `CHK_ASSERT(a_grant_shape, clock, reset, rsp_tvalid && rsp_addr != '0 |-> rsp_size != '0)
endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);
`default_nettype wire
